// ----- hw/rtl/dht_pkg.sv -----
package dht_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int CFG_W        = 11;
    localparam int KEY_W        = 32;
    localparam int PAY_W        = 32;
    localparam int ACT_W        = 2;
    localparam int ST_W         = 3;
    localparam int CNT_W        = 11;
    localparam int SIZE_RESET   = 16;
    localparam int SIZE_MIN     = 2;
    localparam int HASH_MUL     = 23;
    // dividend width for key*23 (32 + 5 bits)
    localparam int DIV_W        = 37;
    localparam int DIV_CW       = $clog2(DIV_W);

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_LOOKUP = 2'd2
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOTFOUND  = 3'd4,
        ST_FOUND     = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } t_mark;

    typedef struct packed {
        logic    load;
        logic    div_step;
        logic    idx_zero;
        logic    idx_home;
        logic    idx_adv;
        logic    unit_step;
        logic    clr_wr;
        logic    ins_wr;
        logic    del_wr;
        logic    result;
        t_status status;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic clr_last;
        logic cnt_last;
        logic hit;
        logic empty;
        logic over_limit;
    } t_stat;

endpackage

// ----- hw/rtl/dht_dp.sv -----
module dht_dp
    import dht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0] i_payload,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output logic             o_valid,
    output logic [ST_W-1:0]  o_status,
    output logic [PAY_W-1:0] o_found_payload,
    output logic [CNT_W-1:0] o_used_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int SW = $clog2(CAPACITY + 1);
    localparam int LW = (SW + 2 > CNT_W + 3) ? SW + 2 : CNT_W + 3;
    localparam int MKW = KEY_W + 2;

    logic [CFG_W-1:0] r_table_size;
    logic [SW-1:0]    r_s;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_payload;
    logic [DIV_W-1:0] r_div_a, r_div_b;
    logic [SW-1:0]    r_rem_a, r_rem_b;
    logic [DIV_CW-1:0] r_div_cnt;
    logic [SW-1:0]    r_idx, r_cnt;
    logic [AW-1:0]    r_clr_addr;
    logic [CNT_W-1:0] r_live, r_tomb;
    logic [CNT_W-1:0] n_live;
    logic [MKW-1:0]   r_rd_mk;
    logic [PAY_W-1:0] r_rd_pl;
    logic             r_valid;
    logic [ST_W-1:0]  r_status;
    logic [PAY_W-1:0] r_found;
    logic [CNT_W-1:0] r_used;

    logic [MKW-1:0]   mem_mk [CAPACITY];
    logic [PAY_W-1:0] mem_pl [CAPACITY];

    logic [SW:0]      rem_a_sh, rem_b_sh;
    logic [SW-1:0]    step, inc, nxt;
    logic [SW:0]      sum;
    logic [SW-1:0]    s_clamp;
    logic             mk_we;
    logic [AW-1:0]    mk_wa;
    logic [MKW-1:0]   mk_wd;
    logic [LW-1:0]    lim_lhs, lim_rhs;
    t_mark            rd_mark;

    // one restoring remainder step on each dividend
    assign rem_a_sh = {r_rem_a, r_div_a[DIV_W-1]};
    assign rem_b_sh = {r_rem_b, r_div_b[DIV_W-1]};

    assign step = (r_rem_b == '0) ? SW'(1) : r_rem_b;
    assign inc  = i_cmd.unit_step ? SW'(1) : step;
    assign sum  = {1'b0, r_idx} + {1'b0, inc};
    assign nxt  = (sum >= {1'b0, r_s}) ? SW'(sum - {1'b0, r_s}) : sum[SW-1:0];

    always_comb begin
        if (r_table_size < CFG_W'(SIZE_MIN)) begin
            s_clamp = SW'(SIZE_MIN);
        end else if (32'(r_table_size) > CAPACITY) begin
            s_clamp = SW'(CAPACITY);
        end else begin
            s_clamp = SW'(r_table_size);
        end
    end

    assign lim_lhs = (LW'(r_live) + LW'(r_tomb) + LW'(1)) << 2;
    assign lim_rhs = LW'(r_s) + (LW'(r_s) << 1);

    assign rd_mark = t_mark'(r_rd_mk[MKW-1 -: 2]);

    always_comb begin
        o_stat.div_done   = (r_div_cnt == DIV_CW'(DIV_W - 1));
        o_stat.clr_last   = (r_clr_addr == AW'(CAPACITY - 1));
        o_stat.cnt_last   = (r_cnt == r_s - SW'(1));
        o_stat.hit        = (rd_mark == MARK_LIVE) && (r_rd_mk[KEY_W-1:0] == r_key);
        o_stat.empty      = (rd_mark == MARK_EMPTY);
        o_stat.over_limit = (lim_lhs > lim_rhs);
    end

    always_comb begin
        n_live = r_live;
        if (i_cmd.ins_wr) begin
            n_live = r_live + CNT_W'(1);
        end else if (i_cmd.del_wr) begin
            n_live = r_live - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= CFG_W'(SIZE_RESET);
            r_clr_addr   <= '0;
            r_live       <= '0;
            r_tomb       <= '0;
            r_valid      <= 1'b0;
            r_div_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_wdata;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            r_live <= n_live;
            if (i_cmd.del_wr) begin
                r_tomb <= r_tomb + CNT_W'(1);
            end
            r_valid <= i_cmd.result;
            if (i_cmd.load) begin
                r_div_cnt <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DIV_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s       <= s_clamp;
            r_key     <= i_key;
            r_payload <= i_payload;
            r_div_a   <= DIV_W'(i_key);
            r_div_b   <= DIV_W'(i_key) * DIV_W'(HASH_MUL);
            r_rem_a   <= '0;
            r_rem_b   <= '0;
        end else if (i_cmd.div_step) begin
            r_div_a <= r_div_a << 1;
            r_div_b <= r_div_b << 1;
            r_rem_a <= (rem_a_sh >= {1'b0, r_s}) ? SW'(rem_a_sh - {1'b0, r_s})
                                                 : rem_a_sh[SW-1:0];
            r_rem_b <= (rem_b_sh >= {1'b0, r_s}) ? SW'(rem_b_sh - {1'b0, r_s})
                                                 : rem_b_sh[SW-1:0];
        end
        if (i_cmd.idx_zero) begin
            r_idx <= '0;
            r_cnt <= '0;
        end else if (i_cmd.idx_home) begin
            r_idx <= r_rem_a;
            r_cnt <= '0;
        end else if (i_cmd.idx_adv) begin
            r_idx <= nxt;
            r_cnt <= r_cnt + SW'(1);
        end
        if (i_cmd.result) begin
            r_status <= i_cmd.status;
            r_found  <= (i_cmd.status == ST_FOUND) ? r_rd_pl : '0;
            r_used   <= n_live;
        end
    end

    // slot store
    assign mk_we = i_cmd.clr_wr | i_cmd.ins_wr | i_cmd.del_wr;
    assign mk_wa = i_cmd.clr_wr ? r_clr_addr : r_idx[AW-1:0];
    always_comb begin
        if (i_cmd.clr_wr) begin
            mk_wd = {MARK_EMPTY, r_key};
        end else if (i_cmd.ins_wr) begin
            mk_wd = {MARK_LIVE, r_key};
        end else begin
            mk_wd = {MARK_TOMB, r_key};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            mem_mk[mk_wa] <= mk_wd;
        end
        r_rd_mk <= mem_mk[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_wr) begin
            mem_pl[r_idx[AW-1:0]] <= r_payload;
        end
        r_rd_pl <= mem_pl[r_idx[AW-1:0]];
    end

    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_found_payload = r_found;
    assign o_used_count    = r_used;

endmodule

// ----- hw/rtl/dht_ctrl.sv -----
module dht_ctrl
    import dht_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic [ACT_W-1:0] i_action,
    input  t_stat            i_stat,
    output t_cmd             o_cmd,
    output logic             busy
);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_DIV, S_HOME, S_SCAN_RD, S_SCAN_CHK, S_PRB_RD, S_PRB_CHK
    } t_state;

    t_state           r_state, n_state;
    logic [ACT_W-1:0] r_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_op    <= ACT_INSERT;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_op <= i_action;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_NOTFOUND;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_action == ACT_INSERT || i_action == ACT_DELETE ||
                        i_action == ACT_LOOKUP) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DIV;
                    end else begin
                        o_cmd.result = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_done) begin
                    n_state = S_HOME;
                end
            end
            S_HOME: begin
                if (r_op == ACT_INSERT) begin
                    o_cmd.idx_zero = 1'b1;
                    n_state        = S_SCAN_RD;
                end else begin
                    o_cmd.idx_home = 1'b1;
                    n_state        = S_PRB_RD;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CHK;
            S_SCAN_CHK: begin
                priority if (i_stat.hit) begin
                    o_cmd.result = 1'b1;
                    o_cmd.status = ST_DUPLICATE;
                    n_state      = S_IDLE;
                end else if (i_stat.cnt_last && i_stat.over_limit) begin
                    o_cmd.result = 1'b1;
                    o_cmd.status = ST_FULL;
                    n_state      = S_IDLE;
                end else if (i_stat.cnt_last) begin
                    o_cmd.idx_home = 1'b1;
                    n_state        = S_PRB_RD;
                end else begin
                    o_cmd.idx_adv   = 1'b1;
                    o_cmd.unit_step = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_PRB_RD: n_state = S_PRB_CHK;
            S_PRB_CHK: begin
                priority if (r_op == ACT_INSERT && i_stat.empty) begin
                    o_cmd.ins_wr = 1'b1;
                    o_cmd.result = 1'b1;
                    o_cmd.status = ST_INSERTED;
                    n_state      = S_IDLE;
                end else if (r_op != ACT_INSERT && i_stat.hit) begin
                    o_cmd.del_wr = (r_op == ACT_DELETE);
                    o_cmd.result = 1'b1;
                    o_cmd.status = (r_op == ACT_DELETE) ? ST_DELETED : ST_FOUND;
                    n_state      = S_IDLE;
                end else if (i_stat.cnt_last) begin
                    o_cmd.result = 1'b1;
                    o_cmd.status = (r_op == ACT_INSERT) ? ST_FULL : ST_NOTFOUND;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.idx_adv = 1'b1;
                    n_state       = S_PRB_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- hw/rtl/double_hash_table.sv -----
// Open-addressing hash table with double hashing. After reset the block sweeps
// every slot to empty, one slot a cycle, and holds busy high until it is done.
// An item is taken when start is high and busy low; the result then appears on
// o_status/o_found_payload/o_used_count with o_valid high for exactly one cycle,
// and the receiver cannot stall it. An operation forms the bit-serial remainder
// of key and 23*key by the table size S, then reads and checks slots: lookup
// and delete visit up to S slots; insert scans up to S slots for a duplicate,
// answers full if past the load limit, and else probes up to S more. An undefined
// action answers not found on the cycle after it is taken. table_size may be
// written only while busy is low and no item is in flight.
module double_hash_table
    import dht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    input  logic [ACT_W-1:0] i_action,
    input  logic [KEY_W-1:0] i_key,
    input  logic [PAY_W-1:0] i_payload,
    output logic             o_valid,
    output logic [ST_W-1:0]  o_status,
    output logic [PAY_W-1:0] o_found_payload,
    output logic [CNT_W-1:0] o_used_count
);

    t_cmd  cmd;
    t_stat stat;

    dht_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    dht_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_key           (i_key),
        .i_payload       (i_payload),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_found_payload (o_found_payload),
        .o_used_count    (o_used_count)
    );

endmodule
